// File: rtl/sfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types and constants of the sensor frame CRC checker
// Frame layout, CRC-16 constants and the status codes of one result word.
// ----------------------------------------------------------------------------
package sfcc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned IDX_W  = 3;

	localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
	localparam logic [BYTE_W-1:0] FUNC_CODE = 8'h03;
	localparam logic [BYTE_W-1:0] LEN_CODE  = 8'h04;

	// byte positions within a frame
	localparam logic [IDX_W-1:0] POS_FUNC    = 3'd0;
	localparam logic [IDX_W-1:0] POS_LEN     = 3'd1;
	localparam logic [IDX_W-1:0] POS_HUM_HI  = 3'd2;
	localparam logic [IDX_W-1:0] POS_HUM_LO  = 3'd3;
	localparam logic [IDX_W-1:0] POS_TMP_HI  = 3'd4;
	localparam logic [IDX_W-1:0] POS_TMP_LO  = 3'd5;
	localparam logic [IDX_W-1:0] POS_CRC_LO  = 3'd6;
	localparam logic [IDX_W-1:0] POS_CRC_HI  = 3'd7;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BAD_FUNC = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_BAD_CRC  = 2'd3
	} status_t;

endpackage
`default_nettype wire

// File: rtl/sfcc_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcc_rx_if: received byte channel
// Valid/ready channel carrying one frame byte and its start-of-frame mark.
// ----------------------------------------------------------------------------
interface sfcc_rx_if
	import sfcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_first;

	modport source (output valid, output rx_byte, output frame_first, input ready);
	modport sink   (input valid, input rx_byte, input frame_first, output ready);
endinterface
`default_nettype wire

// File: rtl/sfcc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcc_res_if: frame result channel
// Valid/ready channel carrying the frame status and the two sensor words.
// ----------------------------------------------------------------------------
interface sfcc_res_if
	import sfcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [WORD_W-1:0] humidity_word;
	logic [WORD_W-1:0] temperature_word;

	modport source (output valid, output status, output humidity_word,
		output temperature_word, input ready);
	modport sink   (input valid, input status, input humidity_word,
		input temperature_word, output ready);
endinterface
`default_nettype wire

// File: rtl/sfcc_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcc_crc_byte: one-byte reflected CRC-16 update
// Eight LSB-first shift steps unrolled into one combinational update.
// ----------------------------------------------------------------------------
module sfcc_crc_byte
	import sfcc_pkg::*;
(
	input  wire logic [CRC_W-1:0]  crc_in,
	input  wire logic [BYTE_W-1:0] data_in,
	output logic      [CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

// File: rtl/sensor_frame_crc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker: sensor response frame checker
// Checks eight-byte sensor frames: header, Modbus CRC-16, data capture.
// ----------------------------------------------------------------------------
// Feed the eight response bytes of a frame on rx, one word per handshake;
// frame_first marks byte 0 and resynchronizes the byte counter (an unmarked
// byte is also taken as byte 0 once the counter has wrapped). Bytes 0..5 go
// through a reflected CRC-16 (init 0xFFFF, poly 0xA001). Byte 0 must be
// function code 0x03, byte 1 length 0x04; bytes 2-3 and 4-5 are the
// big-endian humidity and temperature words, bytes 6-7 the little-endian CRC.
// After byte 7 one result word leaves on res: status 0 good, 1 bad function
// code, 2 bad length, 3 CRC mismatch (header errors win, function over
// length); both data words read zero unless the status is good. A frame cut
// short by a new frame_first gives no result. Rate: one byte per clock,
// sustained; a byte is held in the input register, and the result
// is loaded into the output register at the same edge where byte 7 leaves
// the input register. The only stall is a byte 7 waiting while the previous
// result still sits unread in the output register.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker
	import sfcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sfcc_rx_if.sink   rx,
	sfcc_res_if.source res
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;

	// frame state
	logic [IDX_W-1:0]  byte_index_q;
	logic [CRC_W-1:0]  running_crc_q;
	status_t           header_status_q;
	logic [WORD_W-1:0] humidity_q;
	logic [WORD_W-1:0] temperature_q;
	logic [BYTE_W-1:0] crc_low_q;

	// result register
	logic              res_valid_q;
	status_t           res_status_q;
	logic [WORD_W-1:0] res_hum_q;
	logic [WORD_W-1:0] res_tmp_q;

	logic [IDX_W-1:0]  idx;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_next;
	status_t           hdr_base;
	status_t           hdr_next;
	status_t           final_status;
	logic              last_byte;
	logic              out_free;
	logic              fire_s1;

	// position of the byte in the input register; a mark restarts the frame
	assign idx       = first_s1 ? POS_FUNC : byte_index_q;
	assign crc_base  = (idx == POS_FUNC) ? CRC_INIT : running_crc_q;
	assign hdr_base  = (idx == POS_FUNC) ? ST_GOOD : header_status_q;
	assign last_byte = (idx == POS_CRC_HI);

	// byte 7 needs the result register; all others advance freely
	assign out_free = !res_valid_q || res.ready;
	assign fire_s1  = valid_s1 && (!last_byte || out_free);
	assign rx.ready = !valid_s1 || fire_s1;

	sfcc_crc_byte u_crc (
		.crc_in  (crc_base),
		.data_in (byte_s1),
		.crc_out (crc_next)
	);

	// header check: the first error seen sticks
	always_comb begin
		hdr_next = hdr_base;
		if (idx == POS_FUNC && byte_s1 != FUNC_CODE) begin
			hdr_next = ST_BAD_FUNC;
		end else if (idx == POS_LEN && hdr_base == ST_GOOD && byte_s1 != LEN_CODE) begin
			hdr_next = ST_BAD_LEN;
		end
	end

	// final verdict on byte 7: received CRC is {byte 7, byte 6}
	always_comb begin
		final_status = header_status_q;
		if (header_status_q == ST_GOOD && {byte_s1, crc_low_q} != running_crc_q) begin
			final_status = ST_BAD_CRC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1  <= rx.rx_byte;
			first_s1 <= rx.frame_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			running_crc_q   <= CRC_INIT;
			header_status_q <= ST_GOOD;
		end else if (fire_s1) begin
			byte_index_q    <= idx + IDX_W'(1);
			header_status_q <= hdr_next;
			if (idx < POS_CRC_LO) begin
				running_crc_q <= crc_next;
			end else begin
				running_crc_q <= crc_base;
			end
		end
	end

	// data bytes are always written before byte 7 reads them
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			unique case (idx)
				POS_HUM_HI: humidity_q[15:8]    <= byte_s1;
				POS_HUM_LO: humidity_q[7:0]     <= byte_s1;
				POS_TMP_HI: temperature_q[15:8] <= byte_s1;
				POS_TMP_LO: temperature_q[7:0]  <= byte_s1;
				POS_CRC_LO: crc_low_q           <= byte_s1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_byte) begin
			res_status_q <= final_status;
			res_hum_q    <= (final_status == ST_GOOD) ? humidity_q : '0;
			res_tmp_q    <= (final_status == ST_GOOD) ? temperature_q : '0;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.status           = res_status_q;
	assign res.humidity_word    = res_hum_q;
	assign res.temperature_word = res_tmp_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// a bad frame never leaks data words
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q != ST_GOOD |-> res_hum_q == '0 && res_tmp_q == '0)
		else $error("bad frame result carries nonzero data");

	// the counter wraps to byte 0 after the CRC high byte
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_byte |=> byte_index_q == POS_FUNC)
		else $error("byte counter did not wrap after byte 7");

	// input stalls only behind an unread result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> res_valid_q && !res.ready && last_byte)
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// File: tb/sv/sfcc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_tb_pkg: test bench helpers for the sensor frame CRC checker
// CRC-16 byte step shared by the frame builder and the result checker.
// ----------------------------------------------------------------------------
package sfcc_tb_pkg;
	import sfcc_pkg::*;

	// reflected CRC-16, one byte, lsb first
	function automatic logic [CRC_W-1:0] crc16_shift_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] acc;
		acc = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage

// File: tb/sv/frame_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker: result prediction and compare
// Follows every accepted byte, predicts frame results, checks the result port.
// ----------------------------------------------------------------------------
module frame_result_checker
	import sfcc_pkg::*;
	import sfcc_tb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sfcc_rx_if         rx,
	sfcc_res_if        res,
	output int         mismatch_count,
	output int         pending_results,
	output int         results_checked,
	output int         good_frames
);

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] humidity;
		logic [WORD_W-1:0] temperature;
	} frame_result_t;

	frame_result_t     expected_frames[$];

	// shadow of the frame state
	logic [IDX_W-1:0]  frame_pos;
	logic [CRC_W-1:0]  crc_acc;
	status_t           hdr_status;
	logic [WORD_W-1:0] hum_acc;
	logic [WORD_W-1:0] tmp_acc;
	logic [BYTE_W-1:0] crc_lo;

	task automatic follow_frame_byte(input logic [BYTE_W-1:0] b, input logic first);
		logic [IDX_W-1:0] pos;
		frame_result_t    r;
		pos = first ? POS_FUNC : frame_pos;
		if (pos == POS_FUNC) begin
			crc_acc    = CRC_INIT;
			hdr_status = ST_GOOD;
		end
		if (pos < POS_CRC_LO) begin
			crc_acc = crc16_shift_byte(crc_acc, b);
		end
		case (pos)
			POS_FUNC: begin
				if (b != FUNC_CODE) hdr_status = ST_BAD_FUNC;
			end
			POS_LEN: begin
				if (hdr_status == ST_GOOD && b != LEN_CODE) hdr_status = ST_BAD_LEN;
			end
			POS_HUM_HI: hum_acc[15:8] = b;
			POS_HUM_LO: hum_acc[7:0]  = b;
			POS_TMP_HI: tmp_acc[15:8] = b;
			POS_TMP_LO: tmp_acc[7:0]  = b;
			POS_CRC_LO: crc_lo = b;
			default: begin
				r.status = hdr_status;
				// header errors win over the CRC compare
				if (r.status == ST_GOOD && {b, crc_lo} != crc_acc) r.status = ST_BAD_CRC;
				r.humidity    = (r.status == ST_GOOD) ? hum_acc : '0;
				r.temperature = (r.status == ST_GOOD) ? tmp_acc : '0;
				expected_frames.push_back(r);
			end
		endcase
		frame_pos = pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		status_t       got;
		if (!arst_n) begin
			frame_pos       = '0;
			crc_acc         = CRC_INIT;
			hdr_status      = ST_GOOD;
			hum_acc         = '0;
			tmp_acc         = '0;
			crc_lo          = '0;
			expected_frames.delete();
			mismatch_count  = 0;
			results_checked = 0;
			good_frames     = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_frames.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t: unexpected result status=%0d hum=%h tmp=%h", $realtime,
							res.status, res.humidity_word, res.temperature_word);
				end else begin
					want = expected_frames.pop_front();
					got  = status_t'(res.status);
					results_checked++;
					if (want.status == ST_GOOD) good_frames++;
					if (got != want.status
						|| res.humidity_word != want.humidity
						|| res.temperature_word != want.temperature) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%t: result mismatch: exp %s/%h/%h, got %s/%h/%h",
								$realtime, want.status.name(), want.humidity,
								want.temperature, got.name(),
								res.humidity_word, res.temperature_word);
					end
				end
			end
			if (rx.valid && rx.ready) follow_frame_byte(rx.rx_byte, rx.frame_first);
		end
		pending_results = expected_frames.size();
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sensor frame CRC checker test bench
// Feeds directed and random byte streams, randomly stalls both channels.
// ----------------------------------------------------------------------------
// The source side builds eight-byte frames (good, bad header, bad CRC),
// truncated frames that a new frame_first cuts short, and plain noise. The
// checker instance beside the DUT predicts and compares every result; this
// module only makes stimulus, runs the idle watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import sfcc_pkg::*;
	import sfcc_tb_pkg::*;

	localparam int RANDOM_BYTES = 950;
	localparam int IDLE_LIMIT   = 500;
	localparam int DRAIN_CYCLES = 10;

	typedef enum int {
		HDR_OK,
		HDR_BAD_FUNC,
		HDR_BAD_LEN,
		HDR_BAD_BOTH
	} header_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	sfcc_rx_if  rx_ch ();
	sfcc_res_if res_ch ();

	int mismatch_count;
	int pending_results;
	int results_checked;
	int good_frames;

	int bytes_sent;
	int directed_bytes;
	int idle_cycles;
	bit src_calm;                         // no gaps while set

	logic [BYTE_W-1:0] frame_bytes [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sensor_frame_crc_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	frame_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx_ch),
		.res             (res_ch),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results),
		.results_checked (results_checked),
		.good_frames     (good_frames)
	);

	// word values lean toward the extremes now and then
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return WORD_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] byte_other_than(input logic [BYTE_W-1:0] avoid);
		logic [BYTE_W-1:0] v;
		do v = BYTE_W'($urandom_range(0, 255)); while (v == avoid);
		return v;
	endfunction

	// fills frame_bytes; the CRC covers the header as sent, so a bad header
	// can still carry a matching CRC
	task automatic build_frame(input header_kind_t hk, input bit crc_ok,
		input logic [WORD_W-1:0] hum, input logic [WORD_W-1:0] tmp);
		logic [CRC_W-1:0] crc;
		frame_bytes[POS_FUNC] = (hk == HDR_BAD_FUNC || hk == HDR_BAD_BOTH) ?
			byte_other_than(FUNC_CODE) : FUNC_CODE;
		frame_bytes[POS_LEN] = (hk == HDR_BAD_LEN || hk == HDR_BAD_BOTH) ?
			byte_other_than(LEN_CODE) : LEN_CODE;
		frame_bytes[POS_HUM_HI] = hum[15:8];
		frame_bytes[POS_HUM_LO] = hum[7:0];
		frame_bytes[POS_TMP_HI] = tmp[15:8];
		frame_bytes[POS_TMP_LO] = tmp[7:0];
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++) crc = crc16_shift_byte(crc, frame_bytes[i]);
		if (!crc_ok) crc ^= CRC_W'($urandom_range(1, 16'hFFFF));
		frame_bytes[POS_CRC_LO] = crc[7:0];
		frame_bytes[POS_CRC_HI] = crc[15:8];
	endtask

	// called and returns at a falling edge; valid stays high across
	// back-to-back words
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid       <= 1'b1;
		rx_ch.rx_byte     <= b;
		rx_ch.frame_first <= first;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int n, input logic mark);
		for (int i = 0; i < n; i++) push_byte(frame_bytes[i], (i == 0) ? mark : 1'b0);
	endtask

	// stimulus
	initial begin
		int  pick;
		int  n;
		bit  aligned;
		header_kind_t hk;
		arst_n              = 1'b0;
		rx_ch.valid         = 1'b0;
		rx_ch.rx_byte       = '0;
		rx_ch.frame_first   = 1'b0;
		bytes_sent          = 0;
		src_calm            = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: good frame at the word extremes with the sign bit set
		build_frame(HDR_OK, 1'b1, 16'hFFFF, 16'h8000);
		send_frame(8, 1'b1);
		// unmarked start after wrap; both header bytes wrong plus bad CRC,
		// function code error must win
		build_frame(HDR_BAD_BOTH, 1'b0, 16'h1234, 16'h5678);
		send_frame(8, 1'b0);
		// frame cut short after two bytes, no result
		build_frame(HDR_OK, 1'b1, 16'hAAAA, 16'h5555);
		send_frame(2, 1'b1);
		// resync into a bad length frame with zero words and a good CRC
		build_frame(HDR_BAD_LEN, 1'b1, 16'h0000, 16'h0000);
		send_frame(8, 1'b1);
		directed_bytes = bytes_sent;

		aligned = 1'b1;
		while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0) src_calm = !src_calm;
			if (pick < 70) begin
				// well-formed frame, mostly good
				case ($urandom_range(0, 19))
					0:       hk = HDR_BAD_FUNC;
					1:       hk = HDR_BAD_LEN;
					2:       hk = HDR_BAD_BOTH;
					default: hk = HDR_OK;
				endcase
				build_frame(hk, $urandom_range(0, 6) != 0, pick_word(), pick_word());
				send_frame(8, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (pick < 85) begin
				build_frame(HDR_OK, 1'b1, pick_word(), pick_word());
				send_frame($urandom_range(1, 7), 1'b1);
				aligned = 1'b0;
			end else begin
				// noise with stray frame marks
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
				aligned = 1'b0;
			end
		end
		// close on a full frame so the last word is a result
		build_frame(HDR_OK, 1'b1, pick_word(), pick_word());
		send_frame(8, 1'b1);
		rx_ch.valid <= 1'b0;

		while (pending_results != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Summary: %0d bytes fed (%0d directed), %0d frame results checked, %0d good.",
			bytes_sent, directed_bytes, results_checked, good_frames);
		$display("Mismatches: %0d", mismatch_count);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// result sink: random stall per word, with stall-free stretches
	initial begin
		int stall;
		int calm_left;
		res_ch.ready = 1'b0;
		calm_left    = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = $urandom_range(0, 10);
				if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 20);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	// watchdog: any accepted word on either channel clears it
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
